[design/brt_pkg.sv]
// brt_pkg: shared types and codes for the block request tracker
// controller states, controller/datapath command and status structs, field codes
// no dependencies
package brt_pkg;

    localparam logic [1:0] CMD_REFILL   = 2'd0;
    localparam logic [1:0] CMD_DISPATCH = 2'd1;
    localparam logic [1:0] CMD_RECEIVE  = 2'd2;
    localparam logic [1:0] CMD_SWEEP    = 2'd3;

    localparam logic [1:0] ST_ZERO      = 2'd0;
    localparam logic [1:0] ST_DONE_OK   = 2'd1;
    localparam logic [1:0] ST_NONE_PEND = 2'd2;

    localparam logic REG_LAST_BLOCK = 1'b0;
    localparam logic REG_TIMEOUT    = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_REF_TEST,
        S_REF_SCAN,
        S_REF_APPLY,
        S_DSP_SCAN,
        S_DSP_APPLY,
        S_DSP_FLUSH,
        S_RCV_SCAN,
        S_RCV_APPLY,
        S_SWP_SCAN,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        SCAN_FIND,
        SCAN_MIN,
        SCAN_SWEEP
    } scan_mode_t;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       ref_init;
        logic       ref_apply;
        logic       dsp_init;
        logic       dsp_apply;
        logic       rcv_apply;
        logic       swp_arm;
        logic       emit;
        logic [1:0] emit_status;
        logic       emit_last;
        logic       emit_pend;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       half_full;
        logic       empty;
        logic       sweep_due;
        logic       ref_stop;
        logic       scan_done;
        logic       found;
        logic       best_found;
        logic       pend_valid;
        logic       k_last;
    } ctl_stat_t;

endpackage

[design/brt_ram.sv]
// brt_ram: generic single write port, single read port RAM with registered read
// no dependencies
module brt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/brt_ctrl.sv]
// brt_ctrl: command sequencer for the block request tracker
// depends on brt_pkg
module brt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  brt_pkg::ctl_stat_t stat,
    output brt_pkg::ctl_cmd_t  cmd
);
    import brt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.scan_mode = SCAN_FIND;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    CMD_REFILL:
                    begin
                        if (stat.half_full)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.ref_init = 1'b1;
                            state_next = S_REF_TEST;
                        end
                    end
                    CMD_DISPATCH:
                    begin
                        if (stat.empty)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.dsp_init = 1'b1;
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode = SCAN_MIN;
                            state_next = S_DSP_SCAN;
                        end
                    end
                    CMD_RECEIVE:
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode = SCAN_FIND;
                        state_next = S_RCV_SCAN;
                    end
                    default:
                    begin
                        if (stat.sweep_due)
                        begin
                            cmd.swp_arm = 1'b1;
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode = SCAN_SWEEP;
                            state_next = S_SWP_SCAN;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                endcase
            end
            S_REF_TEST:
            begin
                if (stat.ref_stop)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode = SCAN_FIND;
                    state_next = S_REF_SCAN;
                end
            end
            S_REF_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_REF_APPLY;
                end
            end
            S_REF_APPLY:
            begin
                cmd.ref_apply = 1'b1;
                state_next = S_REF_TEST;
            end
            S_DSP_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_DSP_APPLY;
                end
            end
            S_DSP_APPLY:
            begin
                if (stat.best_found)
                begin
                    cmd.dsp_apply = 1'b1;
                    if (stat.pend_valid)
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_status = ST_DONE_OK;
                        cmd.emit_pend = 1'b1;
                    end
                    if (stat.k_last)
                    begin
                        state_next = S_DSP_FLUSH;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode = SCAN_MIN;
                        state_next = S_DSP_SCAN;
                    end
                end
                else
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_pend = stat.pend_valid;
                    cmd.emit_status = stat.pend_valid ? ST_DONE_OK : ST_NONE_PEND;
                    state_next = S_IDLE;
                end
            end
            S_DSP_FLUSH:
            begin
                cmd.emit = 1'b1;
                cmd.emit_last = 1'b1;
                cmd.emit_pend = 1'b1;
                cmd.emit_status = ST_DONE_OK;
                state_next = S_IDLE;
            end
            S_RCV_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_RCV_APPLY;
                end
            end
            S_RCV_APPLY:
            begin
                cmd.rcv_apply = 1'b1;
                cmd.emit = 1'b1;
                cmd.emit_last = 1'b1;
                cmd.emit_status = stat.found ? ST_DONE_OK : ST_ZERO;
                state_next = S_IDLE;
            end
            S_SWP_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.emit = 1'b1;
                cmd.emit_last = 1'b1;
                cmd.emit_status = ST_ZERO;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/brt_dpath.sv]
// brt_dpath: slot table, scan pipeline, counters and result registers
// depends on brt_pkg and brt_ram
module brt_dpath #(
    parameter int TABLE_SLOTS = 64,
    parameter int BATCH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [31:0]       cfg_wdata,
    input  logic [1:0]        cmd_in,
    input  logic [31:0]       block_number,
    input  logic [31:0]       now,
    input  brt_pkg::ctl_cmd_t  cmd,
    output brt_pkg::ctl_stat_t stat,
    output logic              res_valid,
    output logic [1:0]        status,
    output logic [31:0]       block_number_res,
    output logic              last,
    output logic [6:0]        occupancy
);
    import brt_pkg::*;

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int KW = $clog2(BATCH + 1);

    logic [31:0] last_block_reg, timeout_reg;
    logic [1:0]  cmd_reg;
    logic [31:0] blk_reg, now_reg;
    logic [31:0] next_block_reg, last_sweep_reg;
    logic [CW-1:0] count_reg, count_next, n_reg;
    logic [KW-1:0] k_reg;
    logic [TABLE_SLOTS-1:0] valid_reg, req_reg;

    logic [AW:0]   scan_cnt_reg;
    logic          scan_act_reg, p_act_reg;
    logic [AW-1:0] p_idx_reg;
    scan_mode_t    mode_reg;

    logic          found_reg, free_found_reg, best_found_reg, pend_valid_reg;
    logic [AW-1:0] found_idx_reg, free_idx_reg, best_idx_reg;
    logic [31:0]   best_blk_reg, pend_reg;

    logic [31:0] rd_blk, rd_stamp, key;
    logic        blk_we, stamp_we;

    assign key = (cmd_reg == CMD_RECEIVE) ? blk_reg : next_block_reg;
    assign blk_we = cmd.ref_apply && !found_reg;
    assign stamp_we = cmd.dsp_apply;

    brt_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS)) u_blk_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (free_idx_reg),
        .wdata (next_block_reg),
        .raddr (scan_cnt_reg[AW-1:0]),
        .rdata (rd_blk)
    );

    brt_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS)) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (best_idx_reg),
        .wdata (now_reg),
        .raddr (scan_cnt_reg[AW-1:0]),
        .rdata (rd_stamp)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ref_apply && !found_reg)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.rcv_apply && found_reg)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        stat.cmd = cmd_reg;
        stat.half_full = (32'(count_reg) >= TABLE_SLOTS / 2);
        stat.empty = (count_reg == '0);
        stat.sweep_due = ((now_reg - last_sweep_reg) > timeout_reg);
        stat.ref_stop = (32'(n_reg) >= TABLE_SLOTS) || (next_block_reg > last_block_reg);
        stat.scan_done = p_act_reg && (32'(p_idx_reg) == TABLE_SLOTS - 1);
        stat.found = found_reg;
        stat.best_found = best_found_reg;
        stat.pend_valid = pend_valid_reg;
        stat.k_last = ((32'(k_reg) + 32'd1) == BATCH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_block_reg <= '0;
            timeout_reg <= 32'd300000;
            next_block_reg <= '0;
            last_sweep_reg <= '0;
            count_reg <= '0;
            valid_reg <= '0;
            req_reg <= '0;
            scan_act_reg <= 1'b0;
            p_act_reg <= 1'b0;
            res_valid <= 1'b0;
            pend_valid_reg <= 1'b0;
            found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            found_idx_reg <= '0;
            free_idx_reg <= '0;
            best_idx_reg <= '0;
            best_blk_reg <= '0;
            pend_reg <= '0;
            cmd_reg <= CMD_REFILL;
            mode_reg <= SCAN_FIND;
            scan_cnt_reg <= '0;
            n_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_LAST_BLOCK)
                begin
                    last_block_reg <= cfg_wdata;
                end
                else
                begin
                    timeout_reg <= cfg_wdata;
                end
            end
            if (cmd.load)
            begin
                cmd_reg <= cmd_in;
            end
            count_reg <= count_next;

            // scan address stage
            if (cmd.scan_start)
            begin
                scan_act_reg <= 1'b1;
                scan_cnt_reg <= '0;
                mode_reg <= cmd.scan_mode;
                found_reg <= 1'b0;
                free_found_reg <= 1'b0;
                best_found_reg <= 1'b0;
            end
            else if (scan_act_reg)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
                if (32'(scan_cnt_reg) == TABLE_SLOTS - 1)
                begin
                    scan_act_reg <= 1'b0;
                end
            end
            p_act_reg <= scan_act_reg && !cmd.scan_start;

            // scan compare stage
            if (p_act_reg)
            begin
                case (mode_reg)
                    SCAN_FIND:
                    begin
                        if (valid_reg[p_idx_reg] && rd_blk == key && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            found_idx_reg <= p_idx_reg;
                        end
                        if (!valid_reg[p_idx_reg] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg <= p_idx_reg;
                        end
                    end
                    SCAN_MIN:
                    begin
                        if (valid_reg[p_idx_reg] && !req_reg[p_idx_reg]
                            && (!best_found_reg || rd_blk < best_blk_reg))
                        begin
                            best_found_reg <= 1'b1;
                            best_idx_reg <= p_idx_reg;
                            best_blk_reg <= rd_blk;
                        end
                    end
                    default:
                    begin
                        if (valid_reg[p_idx_reg] && req_reg[p_idx_reg]
                            && (now_reg - rd_stamp) > timeout_reg)
                        begin
                            req_reg[p_idx_reg] <= 1'b0;
                        end
                    end
                endcase
            end

            if (cmd.ref_init)
            begin
                n_reg <= count_reg;
            end
            if (cmd.ref_apply)
            begin
                if (found_reg)
                begin
                    req_reg[found_idx_reg] <= 1'b0;
                end
                else
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                    req_reg[free_idx_reg] <= 1'b0;
                end
                next_block_reg <= next_block_reg + 32'd1;
                n_reg <= n_reg + 1'b1;
            end

            if (cmd.dsp_init)
            begin
                k_reg <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.dsp_apply)
            begin
                req_reg[best_idx_reg] <= 1'b1;
                pend_reg <= best_blk_reg;
                pend_valid_reg <= 1'b1;
                k_reg <= k_reg + 1'b1;
            end

            if (cmd.rcv_apply && found_reg)
            begin
                valid_reg[found_idx_reg] <= 1'b0;
                req_reg[found_idx_reg] <= 1'b0;
            end

            if (cmd.swp_arm)
            begin
                last_sweep_reg <= now_reg;
            end

            res_valid <= cmd.emit;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            blk_reg <= block_number;
            now_reg <= now;
        end
        p_idx_reg <= scan_cnt_reg[AW-1:0];
        if (cmd.emit)
        begin
            status <= cmd.emit_status;
            block_number_res <= cmd.emit_pend ? pend_reg : 32'd0;
            last <= cmd.emit_last;
            occupancy <= 7'(count_next);
        end
    end

endmodule

[design/block_request_tracker.sv]
// block_request_tracker: top level of the outstanding block table
// depends on brt_pkg, brt_ctrl, brt_dpath, brt_ram
//
//  channel  | handshake          | fields
//  command  | start / busy       | cmd, block_number, now
//  result   | res_valid (strobe) | status, block_number_res, last, occupancy
//  config   | cfg_we             | cfg_addr, cfg_wdata
//
// a table walk reads one slot per cycle from the block and stamp RAMs
// receive and a due sweep: one table walk from acceptance to the result strobe
// skipped refill or sweep, dispatch of an empty table: no table walk
// dispatch: one walk per block, plus a final one when fewer than BATCH are found; BATCH walks at most
// refill: one table walk per attempted block, up to TABLE_SLOTS attempts
// reset clears valid and requested flags at once; no clearing pass; the receiver cannot stall
module block_request_tracker #(
    parameter int TABLE_SLOTS = 64,
    parameter int BATCH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [31:0] block_number,
    input  logic [31:0] now,
    output logic        res_valid,
    output logic [1:0]  status,
    output logic [31:0] block_number_res,
    output logic        last,
    output logic [6:0]  occupancy,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import brt_pkg::*;

    ctl_cmd_t  ctl_cmd;
    ctl_stat_t ctl_stat;

    brt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (ctl_stat),
        .cmd   (ctl_cmd)
    );

    brt_dpath #(.TABLE_SLOTS(TABLE_SLOTS), .BATCH(BATCH)) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .cmd_in           (cmd),
        .block_number     (block_number),
        .now              (now),
        .cmd              (ctl_cmd),
        .stat             (ctl_stat),
        .res_valid        (res_valid),
        .status           (status),
        .block_number_res (block_number_res),
        .last             (last),
        .occupancy        (occupancy)
    );

endmodule

[design/brt_checker.sv]
// brt_checker: port level assertions for block_request_tracker, bound to the top level
// depends on brt_pkg
module brt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        res_valid,
    input logic [1:0]  status,
    input logic [31:0] block_number_res,
    input logic        last
);
    import brt_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && last |=> !res_valid)
        else $error("result strobe right after final result");

    a_block_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && block_number_res != 32'd0 |-> status == ST_DONE_OK)
        else $error("nonzero block without dispatched status");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> !res_valid)
        else $error("result while idle");

endmodule

bind block_request_tracker brt_checker u_brt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .res_valid        (res_valid),
    .status           (status),
    .block_number_res (block_number_res),
    .last             (last)
);

[sim/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for block_request_tracker, directed table then random commands
// results checked against an in-bench copy of the outstanding block table
// depends on brt_pkg and the block_request_tracker RTL
module tb;
    import brt_pkg::*;

    localparam int SLOTS = 64;
    localparam int BATCH = 8;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] blk;
        logic        last;
        logic [6:0]  occ;
    } tracker_res_t;

    typedef struct packed {
        logic [1:0]   cmd;
        logic [31:0]  blk;
        logic [31:0]  now;
        logic         typed;
        tracker_res_t res;
    } cmd_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [31:0] block_number;
    logic [31:0] now;
    logic        res_valid;
    logic [1:0]  status;
    logic [31:0] block_number_res;
    logic        last;
    logic [6:0]  occupancy;
    logic        cfg_we;
    logic        cfg_addr;
    logic [31:0] cfg_wdata;

    block_request_tracker #(.TABLE_SLOTS(SLOTS), .BATCH(BATCH)) dut (.*);

    // predicted table state
    logic        tab_valid [SLOTS];
    logic [31:0] tab_block [SLOTS];
    logic        tab_req   [SLOTS];
    logic [31:0] tab_stamp [SLOTS];
    logic [31:0] next_blk;
    logic [31:0] sweep_time;
    int          entry_cnt;
    logic [31:0] last_blk_reg;
    logic [31:0] timeout_reg;

    tracker_res_t expected_q[$];
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    logic [31:0] tick;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int find_slot(logic [31:0] b);
        for (int i = 0; i < SLOTS; i++)
            if (tab_valid[i] && tab_block[i] == b)
                return i;
        return -1;
    endfunction

    function automatic tracker_res_t mk_res(logic [1:0] st, logic [31:0] b, logic l);
        tracker_res_t r;
        r.status = st;
        r.blk = b;
        r.last = l;
        r.occ = entry_cnt[6:0];
        return r;
    endfunction

    // update the table for one command and return its results
    task automatic track_command(input logic [1:0] c, input logic [31:0] b,
                                 input logic [31:0] t, ref tracker_res_t res[$]);
        int s;
        int best;
        res = {};
        case (c)
            CMD_REFILL:
            begin
                if (entry_cnt < SLOTS / 2)
                begin
                    for (int n = entry_cnt; n < SLOTS; n++)
                    begin
                        if (next_blk > last_blk_reg)
                            break;
                        s = find_slot(next_blk);
                        if (s >= 0)
                            tab_req[s] = 1'b0;
                        else
                            for (int i = 0; i < SLOTS; i++)
                                if (!tab_valid[i])
                                begin
                                    tab_valid[i] = 1'b1;
                                    tab_block[i] = next_blk;
                                    tab_req[i] = 1'b0;
                                    tab_stamp[i] = '0;
                                    entry_cnt++;
                                    break;
                                end
                        next_blk = next_blk + 32'd1;
                    end
                end
                res = {res, mk_res(ST_ZERO, '0, 1'b1)};
            end
            CMD_DISPATCH:
            begin
                if (entry_cnt == 0)
                    res = {res, mk_res(ST_ZERO, '0, 1'b1)};
                else
                begin
                    for (int k = 0; k < BATCH; k++)
                    begin
                        best = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (tab_valid[i] && !tab_req[i] &&
                                (best < 0 || tab_block[i] < tab_block[best]))
                                best = i;
                        if (best < 0)
                            break;
                        tab_req[best] = 1'b1;
                        tab_stamp[best] = t;
                        res = {res, mk_res(ST_DONE_OK, tab_block[best], 1'b0)};
                    end
                    if (res.size() == 0)
                        res = {res, mk_res(ST_NONE_PEND, '0, 1'b1)};
                    else
                        res[res.size()-1].last = 1'b1;
                end
            end
            CMD_RECEIVE:
            begin
                s = find_slot(b);
                if (s >= 0)
                begin
                    tab_valid[s] = 1'b0;
                    tab_req[s] = 1'b0;
                    entry_cnt--;
                    res = {res, mk_res(ST_DONE_OK, '0, 1'b1)};
                end
                else
                    res = {res, mk_res(ST_ZERO, '0, 1'b1)};
            end
            default:
            begin
                if (t - sweep_time > timeout_reg)
                begin
                    sweep_time = t;
                    for (int i = 0; i < SLOTS; i++)
                        if (tab_valid[i] && tab_req[i] && (t - tab_stamp[i]) > timeout_reg)
                            tab_req[i] = 1'b0;
                end
                res = {res, mk_res(ST_ZERO, '0, 1'b1)};
            end
        endcase
    endtask

    // result checker
    always @(posedge clk)
    begin
        tracker_res_t e;
        if (rst_n && res_valid)
        begin
            n_results++;
            if (expected_q.size() == 0)
            begin
                $error("result with no transaction pending: status %0d blk %0d",
                       status, block_number_res);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, status);
                    errors++;
                end
                if (block_number_res !== e.blk)
                begin
                    $error("block_number_res: expected %0d, actual %0d", e.blk,
                           block_number_res);
                    errors++;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0d, actual %0d", e.last, last);
                    errors++;
                end
                if (occupancy !== e.occ)
                begin
                    $error("occupancy: expected %0d, actual %0d", e.occ, occupancy);
                    errors++;
                end
            end
        end
    end

    task automatic wait_idle();
        while (expected_q.size() != 0)
            @(negedge clk);
        while (busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic a, input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (a == REG_LAST_BLOCK)
            last_blk_reg = v;
        else
            timeout_reg = v;
    endtask

    // caller stands at a falling edge; returns at the falling edge after acceptance
    task automatic issue(input logic [1:0] c, input logic [31:0] b, input logic [31:0] t,
                         input bit typed, input tracker_res_t tr, input bit may_idle);
        tracker_res_t res[$];
        if (may_idle && $urandom_range(0, 99) < 6)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        block_number <= b;
        now <= t;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        track_command(c, b, t, res);
        n_items++;
        if (typed)
            expected_q = {expected_q, tr};
        else
            foreach (res[i])
                expected_q = {expected_q, res[i]};
        @(negedge clk);
    endtask

    function automatic logic [1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return CMD_REFILL;
        if (r < 50) return CMD_DISPATCH;
        if (r < 85) return CMD_RECEIVE;
        return CMD_SWEEP;
    endfunction

    function automatic logic [31:0] pick_block();
        int live[$];
        for (int i = 0; i < SLOTS; i++)
            if (tab_valid[i])
                live = {live, i};
        if (live.size() != 0 && $urandom_range(0, 99) < 75)
            return tab_block[live[$urandom_range(0, live.size()-1)]];
        if ($urandom_range(0, 1))
            return $urandom;
        return next_blk + $urandom_range(0, 3);
    endfunction

    task automatic random_phase(input int count, input logic [31:0] lb,
                                input logic [31:0] tmo);
        logic [1:0] c;
        logic [31:0] t;
        wait_idle();
        write_reg(REG_LAST_BLOCK, lb);
        write_reg(REG_TIMEOUT, tmo);
        for (int i = 0; i < count; i++)
        begin
            c = pick_cmd();
            if ($urandom_range(0, 19) == 0)
                tick = $urandom;
            else if (tmo < 1000)
                tick = tick + $urandom_range(0, 2 * tmo + 2);
            else
                tick = tick + $urandom_range(0, 1000);
            t = tick;
            issue(c, (c == CMD_RECEIVE) ? pick_block() : $urandom, t, 1'b0, '0,
                  !(count > 40 && i >= count / 4 && i < count / 2));
        end
    endtask

    cmd_row_t dir_rows [21] = '{
        '{CMD_DISPATCH, 32'd0, 32'd0, 1'b1, '{ST_ZERO, 32'd0, 1'b1, 7'd0}},
        '{CMD_SWEEP, 32'd0, 32'd5, 1'b1, '{ST_ZERO, 32'd0, 1'b1, 7'd0}},
        '{CMD_RECEIVE, 32'd0, 32'd0, 1'b1, '{ST_ZERO, 32'd0, 1'b1, 7'd0}},
        '{CMD_REFILL, 32'd0, 32'd0, 1'b1, '{ST_ZERO, 32'd0, 1'b1, 7'd1}},
        '{CMD_RECEIVE, 32'hFFFF_FFFF, 32'd0, 1'b1, '{ST_ZERO, 32'd0, 1'b1, 7'd1}},
        '{CMD_DISPATCH, 32'd0, 32'd100, 1'b1, '{ST_DONE_OK, 32'd0, 1'b1, 7'd1}},
        '{CMD_DISPATCH, 32'd0, 32'd150, 1'b1, '{ST_NONE_PEND, 32'd0, 1'b1, 7'd1}},
        '{CMD_SWEEP, 32'd0, 32'd300101, 1'b1, '{ST_ZERO, 32'd0, 1'b1, 7'd1}},
        '{CMD_DISPATCH, 32'd0, 32'd300200, 1'b1, '{ST_DONE_OK, 32'd0, 1'b1, 7'd1}},
        '{CMD_REFILL, 32'd0, 32'd0, 1'b1, '{ST_ZERO, 32'd0, 1'b1, 7'd1}},
        '{CMD_RECEIVE, 32'd0, 32'd0, 1'b1, '{ST_DONE_OK, 32'd0, 1'b1, 7'd0}},
        // timeout zero and last block 40 from here
        '{CMD_REFILL, 32'd0, 32'd0, 1'b0, '0},
        '{CMD_DISPATCH, 32'd0, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_DISPATCH, 32'd0, 32'h8000_0000, 1'b0, '0},
        '{CMD_SWEEP, 32'd0, 32'd0, 1'b0, '0},
        '{CMD_RECEIVE, 32'd5, 32'd0, 1'b0, '0},
        '{CMD_RECEIVE, 32'd40, 32'd0, 1'b0, '0},
        '{CMD_REFILL, 32'd0, 32'd0, 1'b0, '0},
        '{CMD_DISPATCH, 32'd0, 32'd1, 1'b0, '0},
        '{CMD_SWEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_DISPATCH, 32'd0, 32'd7, 1'b0, '0}
    };

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_REFILL;
        block_number = '0;
        now = '0;
        cfg_we = 1'b0;
        cfg_addr = REG_LAST_BLOCK;
        cfg_wdata = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tab_valid[i] = 1'b0;
            tab_req[i] = 1'b0;
            tab_block[i] = '0;
            tab_stamp[i] = '0;
        end
        next_blk = '0;
        sweep_time = '0;
        entry_cnt = 0;
        last_blk_reg = '0;
        timeout_reg = 32'd300000;
        tick = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (i == 11)
            begin
                start <= 1'b0;
                wait_idle();
                write_reg(REG_LAST_BLOCK, 32'd40);
                write_reg(REG_TIMEOUT, 32'd0);
            end
            issue(dir_rows[i].cmd, dir_rows[i].blk, dir_rows[i].now, dir_rows[i].typed,
                  dir_rows[i].res, 1'b0);
        end
        start <= 1'b0;

        random_phase(80, 32'd150, 32'd50);
        start <= 1'b0;
        random_phase(40, 32'd300, 32'd0);
        start <= 1'b0;
        random_phase(40, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        start <= 1'b0;
        random_phase(40, 32'hFFFF_FFFF, 32'd1);
        start <= 1'b0;

        wait_idle();
        repeat (200) @(negedge clk);
        $display("ran %0d commands over six register settings, %0d results checked",
                 n_items, n_results);
        if (errors == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[block_request_tracker.f]
design/brt_pkg.sv
design/brt_ram.sv
design/brt_ctrl.sv
design/brt_dpath.sv
design/block_request_tracker.sv
design/brt_checker.sv
sim/tb.sv
